@@ hdl/irff_pkg.sv @@
// Package: shared types and constants for the interval register first-fit allocator.
`timescale 1ns / 1ps

package irff_pkg;

    // Geometry of the occupancy store
    localparam int PC_DEPTH   = 256;
    localparam int PC_W       = 8;
    localparam int MASK_WIDTH = 16;
    localparam int REG_W      = 4;

    // Allocatable register window
    localparam logic [REG_W-1:0] GP_LOW  = 4'd0;
    localparam logic [REG_W-1:0] GP_HIGH = 4'd9;

    // Request codes
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_RESERVE = 2'd1;
    localparam logic [1:0] ACT_ALLOC   = 2'd2;

    // Result codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [PC_W-1:0]  start_pc;
        logic [PC_W-1:0]  end_pc;
        logic [REG_W-1:0] pinned_reg;
        logic [REG_W-1:0] block_size;
    } irff_in_t;

    typedef struct packed {
        logic [REG_W-1:0] chosen_base;
        logic [1:0]       status;
    } irff_out_t;

    // Occupancy store access from the sequencer
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic                  clr;
        logic [PC_W-1:0]       addr;
        logic [MASK_WIDTH-1:0] wr_data;
    } irff_mem_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNION_RD,
        S_UNION_ACC,
        S_SEARCH,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } irff_state_t;

endpackage

@@ hdl/irff_occ_mem.sv @@
// Occupancy store: one mask per program position, per-entry valid bits for fast clear.
`timescale 1ns / 1ps

module irff_occ_mem (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  irff_pkg::irff_mem_req_t         req,
    output logic [irff_pkg::MASK_WIDTH-1:0] rd_data
);

    logic [irff_pkg::MASK_WIDTH-1:0] mem [irff_pkg::PC_DEPTH];
    logic [irff_pkg::PC_DEPTH-1:0]   valid_reg;
    logic [irff_pkg::MASK_WIDTH-1:0] rd_data_reg;
    logic                            rd_valid_reg;

    // Mask array, registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    // Valid bits: reset and clear drop every entry at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.clr) begin
                valid_reg <= '0;
            end else if (req.wr_en) begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    // Entry never written since clear reads as free
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ hdl/interval_register_first_fit.sv @@
// Top level: sequencer and search unit of the first-fit interval register allocator.
// Sequence: a clear, a reversed interval or an unused code goes straight to the result;
//   a reserve marks each position; an allocate unions each position, then makes up to
//   11 tries, one a cycle, and marks each position if placed. One word in flight; each
//   position takes a read and then an update on the single-port occupancy store.
// Reset (aresetn low, synchronous): sequencer idle, output empty, all occupancy free.
`timescale 1ns / 1ps

module interval_register_first_fit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  irff_pkg::irff_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output irff_pkg::irff_out_t m_data
);

    irff_pkg::irff_state_t           state_reg, state_next;
    irff_pkg::irff_in_t              req_reg;
    logic [irff_pkg::PC_W-1:0]       pc_reg;
    logic [irff_pkg::MASK_WIDTH-1:0] busy_reg;
    logic [irff_pkg::MASK_WIDTH-1:0] bits_reg;
    logic [irff_pkg::REG_W-1:0]      base_reg;
    logic [1:0]                      status_reg;
    logic                            m_valid_reg;
    irff_pkg::irff_out_t             m_data_reg;

    irff_pkg::irff_mem_req_t         mem_req;
    logic [irff_pkg::MASK_WIDTH-1:0] mem_rd;

    logic                            s_fire;
    logic                            last_pc;
    logic                            out_free;
    logic                            bad_iv;

    // Search unit
    logic [irff_pkg::REG_W:0]        span;
    logic [31:0]                     want_wide;
    logic [irff_pkg::MASK_WIDTH-1:0] want;
    logic                            out_of_window;
    logic                            fits;

    irff_occ_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    assign s_fire   = s_valid && s_ready;
    assign last_pc  = (pc_reg == req_reg.end_pc);
    assign out_free = !m_valid_reg || m_ready;
    assign bad_iv   = (s_data.end_pc < s_data.start_pc);

    // Block test at the current base
    assign span          = {1'b0, base_reg} + {1'b0, req_reg.block_size};
    assign out_of_window = (span > ({1'b0, irff_pkg::GP_HIGH} + 5'd1))
                        || (span > 5'(irff_pkg::MASK_WIDTH));
    assign want_wide     = ((32'd1 << req_reg.block_size) - 32'd1) << base_reg;
    assign want          = want_wide[irff_pkg::MASK_WIDTH-1:0];
    assign fits          = ((busy_reg & want) == '0);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            irff_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (s_data.action == irff_pkg::ACT_RESERVE && !bad_iv) begin
                        state_next = irff_pkg::S_MARK_RD;
                    end else if (s_data.action == irff_pkg::ACT_ALLOC && !bad_iv) begin
                        state_next = irff_pkg::S_UNION_RD;
                    end else begin
                        state_next = irff_pkg::S_DONE;
                    end
                end
            end
            irff_pkg::S_UNION_RD:  state_next = irff_pkg::S_UNION_ACC;
            irff_pkg::S_UNION_ACC: begin
                state_next = last_pc ? irff_pkg::S_SEARCH : irff_pkg::S_UNION_RD;
            end
            irff_pkg::S_SEARCH: begin
                if (out_of_window) begin
                    state_next = irff_pkg::S_DONE;
                end else if (fits) begin
                    state_next = irff_pkg::S_MARK_RD;
                end
            end
            irff_pkg::S_MARK_RD:   state_next = irff_pkg::S_MARK_WR;
            irff_pkg::S_MARK_WR: begin
                state_next = last_pc ? irff_pkg::S_DONE : irff_pkg::S_MARK_RD;
            end
            irff_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = irff_pkg::S_IDLE;
                end
            end
            default: state_next = irff_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready         = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.clr     = 1'b0;
        mem_req.addr    = pc_reg;
        mem_req.wr_data = mem_rd | bits_reg;
        case (state_reg)
            irff_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                mem_req.clr = s_valid && (s_data.action == irff_pkg::ACT_CLEAR);
            end
            irff_pkg::S_UNION_RD: mem_req.rd_en = 1'b1;
            irff_pkg::S_MARK_RD:  mem_req.rd_en = 1'b1;
            irff_pkg::S_MARK_WR:  mem_req.wr_en = 1'b1;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= irff_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == irff_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            irff_pkg::S_IDLE: begin
                if (s_fire) begin
                    req_reg  <= s_data;
                    pc_reg   <= s_data.start_pc;
                    busy_reg <= '0;
                    bits_reg <= {{(irff_pkg::MASK_WIDTH-1){1'b0}}, 1'b1}
                                << s_data.pinned_reg;
                    // search starts at the window floor; every other word reports base zero
                    if (s_data.action == irff_pkg::ACT_ALLOC && !bad_iv) begin
                        base_reg <= irff_pkg::GP_LOW;
                    end else begin
                        base_reg <= '0;
                    end
                    if ((s_data.action == irff_pkg::ACT_RESERVE
                         || s_data.action == irff_pkg::ACT_ALLOC) && bad_iv) begin
                        status_reg <= irff_pkg::STAT_BAD;
                    end else begin
                        status_reg <= irff_pkg::STAT_DONE;
                    end
                end
            end
            irff_pkg::S_UNION_ACC: begin
                busy_reg <= busy_reg | mem_rd;
                if (!last_pc) begin
                    pc_reg <= pc_reg + 8'd1;
                end
            end
            irff_pkg::S_SEARCH: begin
                if (out_of_window) begin
                    status_reg <= irff_pkg::STAT_NOFIT;
                    base_reg   <= '0;
                end else if (fits) begin
                    bits_reg <= want;
                    pc_reg   <= req_reg.start_pc;
                end else begin
                    base_reg <= base_reg + 4'd1;
                end
            end
            irff_pkg::S_MARK_WR: begin
                if (!last_pc) begin
                    pc_reg <= pc_reg + 8'd1;
                end
            end
            irff_pkg::S_DONE: begin
                if (out_free) begin
                    m_data_reg.chosen_base <= base_reg;
                    m_data_reg.status      <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/irff_checker.sv @@
// Checker: port-level properties of the allocator, bound to the top level.
`timescale 1ns / 1ps

module irff_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input irff_pkg::irff_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input irff_pkg::irff_out_t m_data
);

    // One word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is still in work");

    // A failed result (no fit or bad interval) carries base zero
    a_base_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != irff_pkg::STAT_DONE) |-> (m_data.chosen_base == '0))
        else $error("nonzero base on a refused request");

    // A granted base lies in the allocatable window
    a_base_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.chosen_base <= irff_pkg::GP_HIGH))
        else $error("base outside the register window");

    // Status never takes the unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == irff_pkg::STAT_DONE
                  || m_data.status == irff_pkg::STAT_NOFIT
                  || m_data.status == irff_pkg::STAT_BAD))
        else $error("undefined status code");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed while stalled");

endmodule

bind interval_register_first_fit irff_checker u_irff_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
